// ----- hw/rtl/reciprocal_cycle_length_core_defines.svh -----
// ----------------------------------------------------------------------------
// Reciprocal cycle length - assertion macros
// Shared property templates for the checker; clk_i and rst_ni come from scope.
// ----------------------------------------------------------------------------
`ifndef RECIPROCAL_CYCLE_LENGTH_CORE_DEFINES_SVH
`define RECIPROCAL_CYCLE_LENGTH_CORE_DEFINES_SVH

// same-cycle implication
`define RCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rclen: same-cycle check failed");

// next-cycle implication
`define RCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rclen: next-cycle check failed");

`endif

// ----- hw/rtl/rclen_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reciprocal cycle length - package
// Widths, microcode word layout and the control program.
// ----------------------------------------------------------------------------
package rclen_pkg;

  localparam int unsigned DIV_W  = 10;  // divisor and remainder
  localparam int unsigned STEP_W = 11;  // digit step count, table entries
  localparam int unsigned PROD_W = 14;  // 10 * remainder
  localparam int unsigned DATA_W = 16;  // tdata, padded to bytes
  localparam int unsigned PC_W   = 4;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_INIT,
    OP_READ,
    OP_CHECK,
    OP_REDUCE,
    OP_OUT
  } uop_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_CLR_BUSY,
    C_BAD,
    C_REM_ZERO,
    C_SEEN,
    C_OUT_FULL
  } ucond_e;

  typedef struct packed {
    uop_e        op;
    logic [1:0]  sh;      // reduce step: subtract divisor << sh
    ucond_e      cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic no_input;
    logic clr_busy;
    logic bad;
    logic rem_zero;
    logic seen;
    logic out_full;
  } uflags_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_CLEAR = 4'd1;
  localparam logic [PC_W-1:0] PC_READ  = 4'd3;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd9;
  localparam logic [PC_W-1:0] PC_LAST  = PC_OUT;

  // Control program: jump to target when cond holds, else fall through.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_IDLE, sh: 2'd0, cond: C_NEVER, target: PC_IDLE};
    case (pc)
      4'd0: w = '{op: OP_IDLE,   sh: 2'd0, cond: C_NO_INPUT, target: PC_IDLE};
      4'd1: w = '{op: OP_CLEAR,  sh: 2'd0, cond: C_CLR_BUSY, target: PC_CLEAR};
      4'd2: w = '{op: OP_INIT,   sh: 2'd0, cond: C_BAD,      target: PC_OUT};
      4'd3: w = '{op: OP_READ,   sh: 2'd0, cond: C_REM_ZERO, target: PC_OUT};
      4'd4: w = '{op: OP_CHECK,  sh: 2'd0, cond: C_SEEN,     target: PC_OUT};
      4'd5: w = '{op: OP_REDUCE, sh: 2'd3, cond: C_NEVER,    target: PC_IDLE};
      4'd6: w = '{op: OP_REDUCE, sh: 2'd2, cond: C_NEVER,    target: PC_IDLE};
      4'd7: w = '{op: OP_REDUCE, sh: 2'd1, cond: C_NEVER,    target: PC_IDLE};
      4'd8: w = '{op: OP_REDUCE, sh: 2'd0, cond: C_ALWAYS,   target: PC_READ};
      4'd9: w = '{op: OP_OUT,    sh: 2'd0, cond: C_OUT_FULL, target: PC_OUT};
      default: w = '{op: OP_IDLE, sh: 2'd0, cond: C_ALWAYS,  target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/reciprocal_cycle_length_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reciprocal cycle length - top level
// Period of the decimal expansion of 1/d, one divisor at a time.
// ----------------------------------------------------------------------------
// One divisor word in, one result word out. Each item first clears all
// min(MAX_DIVISOR,1024) entries of the first-seen table through its single
// write port and takes a setup step; then each long-division digit runs a
// table read, a table check/write and four conditional subtracts for
// 10*r mod d. A zero remainder is spotted at the read and a repeated one at
// the check, and a last step loads the output register. A finished result
// waits in the output register while the next divisor is taken and its
// table clear runs.
module reciprocal_cycle_length_core #(
  parameter int unsigned MAX_DIVISOR = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [rclen_pkg::DATA_W-1:0]  s_axis_tdata_i,  // [9:0] divisor
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [rclen_pkg::DATA_W-1:0]  m_axis_tdata_o,  // [9:0] cycle_length
  output logic                          m_axis_tuser_o   // [0] bad divisor: zero or >= MAX_DIVISOR
);
  import rclen_pkg::*;

  localparam int unsigned TBL_DEPTH = (MAX_DIVISOR < 1024) ? MAX_DIVISOR : 1024;
  localparam int unsigned AW        = $clog2(TBL_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(TBL_DEPTH - 1);

  uword_t  uw;
  uflags_t flags;

  logic [STEP_W-1:0] tbl_mem [TBL_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [STEP_W-1:0] mem_wdata;
  logic [STEP_W-1:0] rd_q;

  logic [AW-1:0]     clr_q, clr_d;
  logic              m_valid_q, m_valid_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [DIV_W-1:0]  len_q, len_d;
  logic              bad_q, bad_d;
  logic [DIV_W-1:0]  out_len_q, out_len_d;
  logic              out_bad_q, out_bad_d;
  logic [PROD_W-1:0] div_sh;
  logic              div_bad;

  rclen_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw)
  );

  assign div_bad = (div_q == '0) || (32'(div_q) >= 32'(MAX_DIVISOR));
  assign div_sh  = PROD_W'(div_q) << uw.sh;

  assign flags.no_input = !s_axis_tvalid_i;
  assign flags.clr_busy = (clr_q != CLR_LAST);
  assign flags.bad      = div_bad;
  assign flags.rem_zero = (rem_q == '0);
  assign flags.seen     = (rd_q != '0);
  assign flags.out_full = m_valid_q && !m_axis_tready_i;

  assign s_axis_tready_o = (uw.op == OP_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = DATA_W'(out_len_q);
  assign m_axis_tuser_o  = out_bad_q;

  always_comb begin
    clr_d     = clr_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    div_d     = div_q;
    rem_d     = rem_q;
    step_d    = step_q;
    prod_d    = prod_q;
    len_d     = len_q;
    bad_d     = bad_q;
    out_len_d = out_len_q;
    out_bad_d = out_bad_q;
    mem_we    = 1'b0;
    mem_addr  = rem_q[AW-1:0];
    mem_wdata = '0;
    unique case (uw.op)
      OP_IDLE: begin
        div_d = s_axis_tdata_i[DIV_W-1:0];
      end
      OP_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = flags.clr_busy ? clr_q + 1'b1 : '0;
      end
      OP_INIT: begin
        rem_d  = (div_q == DIV_W'(1)) ? '0 : DIV_W'(1);
        step_d = '0;
        len_d  = '0;
        bad_d  = div_bad;
      end
      OP_READ: begin
        // 10*r as 8r + 2r
        prod_d = (PROD_W'(rem_q) << 3) + (PROD_W'(rem_q) << 1);
      end
      OP_CHECK: begin
        if (flags.seen) begin
          len_d = DIV_W'(step_q - rd_q + 1'b1);
        end else begin
          mem_we    = 1'b1;
          mem_wdata = step_q + 1'b1;
        end
      end
      OP_REDUCE: begin
        if (prod_q >= div_sh) begin
          prod_d = prod_q - div_sh;
        end
        if (uw.sh == 2'd0) begin
          rem_d  = (prod_q >= div_sh) ? DIV_W'(prod_q - div_sh) : DIV_W'(prod_q);
          step_d = step_q + 1'b1;
        end
      end
      OP_OUT: begin
        if (!flags.out_full) begin
          m_valid_d = 1'b1;
          out_len_d = len_q;
          out_bad_d = bad_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q     <= div_d;
    rem_q     <= rem_d;
    step_q    <= step_d;
    prod_q    <= prod_d;
    len_q     <= len_d;
    bad_q     <= bad_d;
    out_len_q <= out_len_d;
    out_bad_q <= out_bad_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_addr] <= mem_wdata;
    end
    if (uw.op == OP_READ) begin
      rd_q <= tbl_mem[rem_q[AW-1:0]];
    end
  end

endmodule

// ----- hw/rtl/rclen_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reciprocal cycle length - microsequencer
// Program counter, control ROM and conditional branch.
// ----------------------------------------------------------------------------
module rclen_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rclen_pkg::uflags_t flags_i,
  output rclen_pkg::uword_t  uword_o
);
  import rclen_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            take;

  assign uw      = ucode(pc_q);
  assign uword_o = uw;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = flags_i.no_input;
      C_CLR_BUSY: take = flags_i.clr_busy;
      C_BAD:      take = flags_i.bad;
      C_REM_ZERO: take = flags_i.rem_zero;
      C_SEEN:     take = flags_i.seen;
      C_OUT_FULL: take = flags_i.out_full;
      default:    take = 1'b0;
    endcase
    if (take) begin
      pc_d = uw.target;
    end else if (pc_q == PC_LAST) begin
      pc_d = PC_IDLE;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- hw/rtl/rclen_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reciprocal cycle length - port checker
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
`include "reciprocal_cycle_length_core_defines.svh"

module rclen_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // one divisor at a time: ready drops right after a word is taken
  `RCL_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // an invalid result carries no length
  `RCL_ASSERT_IMP(a_bad_len_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == 16'd0)
  // period is below the divisor, so the pad bits and the all-ones code never show
  `RCL_ASSERT_IMP(a_len_range, m_axis_tvalid_o,
    m_axis_tdata_o[15:10] == 6'd0 && m_axis_tdata_o[9:0] != 10'h3ff)
  // hold a stalled result
  `RCL_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

endmodule

bind reciprocal_cycle_length_core rclen_chk u_rclen_chk (.*);
